### design/crcfc_pkg.sv
// Package with item types, status codes and the CRC-8 byte update for the reply frame checker.
package crcfc_pkg;

    localparam logic [7:0] CRC_POLY = 8'h8C;

    localparam logic [8:0] POS_HEADER = 9'd0;
    localparam logic [8:0] POS_LENGTH = 9'd1;
    localparam logic [8:0] POS_COMMAND = 9'd2;
    localparam logic [8:0] POS_CHECK = 9'd3;

    localparam logic [1:0] REG_MOTION_CONFLICT = 2'd0;
    localparam logic [1:0] REG_NOT_SUPPORTED = 2'd1;
    localparam logic [1:0] REG_PARAM_ERROR = 2'd2;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_CHECK_ERROR = 3'd1,
        ST_NOT_SUPPORTED = 3'd2,
        ST_LENGTH_ERROR = 3'd3,
        ST_MOTION_CONFLICT = 3'd4,
        ST_PARAM_ERROR = 3'd5
    } status_t;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       action;
        logic [7:0] expected_len;
    } rx_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic       frame_done;
        logic [7:0] command;
        status_t    status;
    } result_t;

    typedef struct packed {
        logic [7:0] move_clash;
        logic [7:0] not_supported;
        logic [7:0] bad_param;
    } codes_t;

    // Reflected CRC-8 update over one byte, least significant bit first.
    function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] data);
        logic [7:0] c;
        c = crc ^ data;
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end
            else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

### design/crcfc_in_stage.sv
// Input register stage that holds one received byte request until the checker core takes it.
module crcfc_in_stage
    import crcfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_ready,
    input  rx_item_t in_item,
    output logic     item_valid,
    output rx_item_t item,
    input  logic     take
);

    logic     valid_reg;
    logic     valid_next;
    rx_item_t item_reg;

    assign in_ready = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item = item_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (in_ready)
        begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            item_reg <= in_item;
        end
    end

endmodule

### design/crcfc_core.sv
// Frame tracking, CRC update, status decision and result register of the reply frame checker.
module crcfc_core
    import crcfc_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     item_valid,
    input  rx_item_t item,
    output logic     take,
    input  codes_t   codes,
    output logic     out_valid,
    input  logic     out_ready,
    output result_t  result
);

    logic [8:0] pos_reg;
    logic [8:0] pos_next;
    logic [7:0] crc_reg;
    logic [7:0] crc_next;
    logic [7:0] check_reg;
    logic [7:0] check_next;
    logic [7:0] length_reg;
    logic [7:0] length_next;
    logic [7:0] command_reg;
    logic [7:0] command_next;
    logic       mode_reg;
    logic       mode_next;
    logic [7:0] plen_reg;
    logic [7:0] plen_next;
    logic       out_valid_reg;
    logic       out_valid_next;
    result_t    result_reg;
    result_t    result_next;

    logic [7:0] crc_base;
    logic [7:0] crc_upd;
    logic [8:0] last_pos;
    logic       done;
    logic       is_payload;
    logic       crc_ok;
    status_t    status;

    assign take = item_valid && (!out_valid_reg || out_ready);
    assign out_valid = out_valid_reg;
    assign result = result_reg;

    always_comb
    begin
        mode_next = mode_reg;
        plen_next = plen_reg;
        length_next = length_reg;
        command_next = command_reg;
        check_next = check_reg;
        is_payload = 1'b0;
        crc_base = (pos_reg == POS_HEADER) ? 8'h00 : crc_reg;
        crc_upd = crc8_update(crc_base, item.rx_byte);
        crc_next = crc_upd;
        case (pos_reg)
            POS_HEADER:
            begin
                mode_next = item.action;
                plen_next = item.expected_len;
            end
            POS_LENGTH:
            begin
                length_next = item.rx_byte;
            end
            POS_COMMAND:
            begin
                command_next = item.rx_byte;
            end
            POS_CHECK:
            begin
                check_next = item.rx_byte;
                crc_next = crc_reg;
            end
            default:
            begin
                is_payload = 1'b1;
            end
        endcase

        last_pos = mode_next ? ({1'b0, plen_next} + 9'd3) : POS_CHECK;
        done = (pos_reg >= last_pos);
        crc_ok = (crc_next == check_next);

        if (mode_next)
        begin
            if (!crc_ok)
            begin
                status = ST_CHECK_ERROR;
            end
            else if (command_next == codes.not_supported)
            begin
                status = ST_NOT_SUPPORTED;
            end
            else if (length_next != plen_next)
            begin
                status = ST_LENGTH_ERROR;
            end
            else
            begin
                status = ST_OK;
            end
        end
        else
        begin
            if (!crc_ok || (length_next != 8'h00))
            begin
                status = ST_CHECK_ERROR;
            end
            else if (command_next == codes.move_clash)
            begin
                status = ST_MOTION_CONFLICT;
            end
            else if (command_next == codes.not_supported)
            begin
                status = ST_NOT_SUPPORTED;
            end
            else if (command_next == codes.bad_param)
            begin
                status = ST_PARAM_ERROR;
            end
            else
            begin
                status = ST_OK;
            end
        end

        result_next.payload_byte = is_payload ? item.rx_byte : 8'h00;
        result_next.payload_valid = is_payload;
        result_next.frame_done = done;
        result_next.command = done ? command_next : 8'h00;
        result_next.status = done ? status : ST_OK;

        if (done)
        begin
            pos_next = POS_HEADER;
            crc_next = 8'h00;
        end
        else
        begin
            pos_next = pos_reg + 9'd1;
        end

        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= POS_HEADER;
            crc_reg <= 8'h00;
            check_reg <= 8'h00;
            length_reg <= 8'h00;
            command_reg <= 8'h00;
            mode_reg <= 1'b0;
            plen_reg <= 8'h00;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            if (take)
            begin
                pos_reg <= pos_next;
                crc_reg <= crc_next;
                check_reg <= check_next;
                length_reg <= length_next;
                command_reg <= command_next;
                mode_reg <= mode_next;
                plen_reg <= plen_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            result_reg <= result_next;
        end
    end

endmodule

### design/crc8_reply_frame_checker_unit.sv
// Top level of the reply frame checker: stream ports, code registers and the two stages.
//
// Received reply bytes enter on the slave stream, one byte per request. The
// first byte of a frame is the header; its request also carries the mode
// (tuser, 0 plain, 1 with payload) and the expected payload length. Then come
// the length, command and check bytes, and in payload mode the payload bytes.
// Every input request gives exactly one result request on the master stream:
// payload bytes are passed through with tuser set, and the last byte of the
// frame carries tlast with the command byte and the status code.
// The user must write the three command codes through the configuration port
// only while no frame traffic is in flight; the block does not enforce it.
// An accepted request is held in the input register and then in the result
// register before its result is presented. One byte can be taken every
// cycle while the receiver does not stall; the CRC-8 byte update is
// combinational. An input register buffers one byte, so a new byte is taken
// while a finished result waits for the receiver. When the receiver stalls,
// the result holds and the input side stalls once the buffer fills.
// Reset clears the frame position, CRC, command codes and both valid flags;
// the next byte after reset is taken as a header.
module crc8_reply_frame_checker_unit
    import crcfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // rx_byte [7:0], expected_len [15:8]
    input  logic        s_tuser,   // action [0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // payload_byte [7:0], command [15:8], status [18:16]
    output logic        m_tuser,   // payload_valid [0]
    output logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata
);

    codes_t   codes_reg;
    codes_t   codes_next;
    rx_item_t in_item;
    rx_item_t item;
    logic     item_valid;
    logic     take;
    result_t  result;

    assign in_item.rx_byte = s_tdata[7:0];
    assign in_item.action = s_tuser;
    assign in_item.expected_len = s_tdata[15:8];

    always_comb
    begin
        codes_next = codes_reg;
        if (cfg_wr_en)
        begin
            case (cfg_addr)
                REG_MOTION_CONFLICT: codes_next.move_clash = cfg_wdata;
                REG_NOT_SUPPORTED:   codes_next.not_supported = cfg_wdata;
                REG_PARAM_ERROR:     codes_next.bad_param = cfg_wdata;
                default:             codes_next = codes_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes_reg <= '0;
        end
        else
        begin
            codes_reg <= codes_next;
        end
    end

    crcfc_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_item    (in_item),
        .item_valid (item_valid),
        .item       (item),
        .take       (take)
    );

    crcfc_core u_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .take       (take),
        .codes      (codes_reg),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .result     (result)
    );

    assign m_tdata = {5'b00000, result.status, result.command, result.payload_byte};
    assign m_tuser = result.payload_valid;
    assign m_tlast = result.frame_done;

endmodule

### dv/crc8_reply_frame_checker_unit_checker.sv
// Watches the reply frame checker's streams, predicts every result request and compares it.
`timescale 1ns / 1ps

module crc8_reply_frame_checker_unit_checker
    import crcfc_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic [15:0] s_tdata,
    input  logic        s_tuser,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [23:0] m_tdata,
    input  logic        m_tuser,
    input  logic        m_tlast,
    input  logic        cfg_wr_en,
    input  logic [1:0]  cfg_addr,
    input  logic [7:0]  cfg_wdata,
    output int          fail_count,
    output int          outstanding
);

    codes_t     codes;
    logic [8:0] frame_pos;
    logic [7:0] crc_acc;
    logic [7:0] check_byte;
    logic [7:0] len_byte;
    logic [7:0] cmd_byte;
    logic       mode_bit;
    logic [7:0] payload_len;

    result_t    replies_due[$];
    result_t    want;
    result_t    seen;

    // Bit-serial form of the reflected CRC-8: data enters least significant bit first.
    function automatic logic [7:0] crc_byte(input logic [7:0] acc, input logic [7:0] data);
        logic [7:0] c;
        logic       fb;
        int         i;
        c = acc;
        for (i = 0; i < 8; i++)
        begin
            fb = c[0] ^ data[i];
            c = {1'b0, c[7:1]};
            if (fb)
            begin
                c = c ^ CRC_POLY;
            end
        end
        return c;
    endfunction

    function automatic status_t frame_verdict();
        logic crc_good;
        crc_good = (crc_acc == check_byte);
        if (mode_bit)
        begin
            if (!crc_good)
                return ST_CHECK_ERROR;
            if (cmd_byte == codes.not_supported)
                return ST_NOT_SUPPORTED;
            if (len_byte != payload_len)
                return ST_LENGTH_ERROR;
            return ST_OK;
        end
        if (!crc_good || len_byte != 8'h00)
            return ST_CHECK_ERROR;
        if (cmd_byte == codes.move_clash)
            return ST_MOTION_CONFLICT;
        if (cmd_byte == codes.not_supported)
            return ST_NOT_SUPPORTED;
        if (cmd_byte == codes.bad_param)
            return ST_PARAM_ERROR;
        return ST_OK;
    endfunction

    function automatic result_t next_reply(input logic [7:0] rx, input logic act,
                                           input logic [7:0] elen);
        result_t    r;
        logic [8:0] last_pos;
        r = '0;
        case (frame_pos)
            POS_HEADER:
            begin
                mode_bit = act;
                payload_len = elen;
                crc_acc = crc_byte(8'h00, rx);
            end
            POS_LENGTH:
            begin
                len_byte = rx;
                crc_acc = crc_byte(crc_acc, rx);
            end
            POS_COMMAND:
            begin
                cmd_byte = rx;
                crc_acc = crc_byte(crc_acc, rx);
            end
            POS_CHECK:
            begin
                check_byte = rx;
            end
            default:
            begin
                crc_acc = crc_byte(crc_acc, rx);
                r.payload_byte = rx;
                r.payload_valid = 1'b1;
            end
        endcase
        last_pos = mode_bit ? ({1'b0, payload_len} + 9'd3) : POS_CHECK;
        if (frame_pos >= last_pos)
        begin
            r.frame_done = 1'b1;
            r.command = cmd_byte;
            r.status = frame_verdict();
            frame_pos = POS_HEADER;
            crc_acc = 8'h00;
        end
        else
        begin
            frame_pos = frame_pos + 9'd1;
        end
        return r;
    endfunction

    task automatic check_field(input string field, input logic [7:0] want_v,
                               input logic [7:0] got_v);
        if (got_v !== want_v)
        begin
            fail_count++;
            $error("%s mismatch: expected %0d, got %0d", field, want_v, got_v);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            codes = '0;
            frame_pos = POS_HEADER;
            crc_acc = 8'h00;
            check_byte = 8'h00;
            len_byte = 8'h00;
            cmd_byte = 8'h00;
            mode_bit = 1'b0;
            payload_len = 8'h00;
            replies_due.delete();
            fail_count = 0;
            outstanding = 0;
        end
        else
        begin
            if (m_tvalid && m_tready)
            begin
                seen.payload_byte = m_tdata[7:0];
                seen.payload_valid = m_tuser;
                seen.frame_done = m_tlast;
                seen.command = m_tdata[15:8];
                seen.status = status_t'(m_tdata[18:16]);
                if (replies_due.size() == 0)
                begin
                    fail_count++;
                    $error("result with no request pending: tdata %h", m_tdata);
                end
                else
                begin
                    want = replies_due.pop_front();
                    check_field("payload_byte", want.payload_byte, seen.payload_byte);
                    check_field("payload_valid", 8'(want.payload_valid),
                                8'(seen.payload_valid));
                    check_field("frame_done", 8'(want.frame_done), 8'(seen.frame_done));
                    check_field("command", want.command, seen.command);
                    check_field("status", 8'(want.status), 8'(seen.status));
                end
            end
            if (cfg_wr_en)
            begin
                case (cfg_addr)
                    REG_MOTION_CONFLICT: codes.move_clash = cfg_wdata;
                    REG_NOT_SUPPORTED:   codes.not_supported = cfg_wdata;
                    REG_PARAM_ERROR:     codes.bad_param = cfg_wdata;
                    default: ;
                endcase
            end
            if (s_tvalid && s_tready)
            begin
                replies_due.push_back(next_reply(s_tdata[7:0], s_tuser, s_tdata[15:8]));
            end
            outstanding = replies_due.size();
        end
    end

endmodule

### dv/crc8_reply_frame_checker_unit_test.sv
// Top of the reply frame checker test: clock, reset, frame stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module crc8_reply_frame_checker_unit_test;
    import crcfc_pkg::*;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata = '0;
    logic        s_tuser = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b1;
    logic [23:0] m_tdata;
    logic        m_tuser;
    logic        m_tlast;
    logic        cfg_wr_en = 1'b0;
    logic [1:0]  cfg_addr = '0;
    logic [7:0]  cfg_wdata = '0;

    int          fail_count;
    int          outstanding;

    logic        s_accept = 1'b0;
    int          burst_left = 0;
    int          items_sent = 0;
    logic [7:0]  code_mc = 8'h00;
    logic [7:0]  code_ns = 8'h00;
    logic [7:0]  code_pe = 8'h00;
    logic [15:0] stall_pattern = '1;
    logic [5:0]  stall_step = '0;

    crc8_reply_frame_checker_unit u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast),
        .cfg_wr_en (cfg_wr_en),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    crc8_reply_frame_checker_unit_checker u_checker (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .fail_count  (fail_count),
        .outstanding (outstanding)
    );

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        s_accept <= s_tvalid && s_tready;
    end

    // The receiver replays a 16-bit ready pattern and draws a new one whenever its 6-bit step counter wraps to zero.
    always @(negedge clk)
    begin
        if (stall_step == 6'd0)
        begin
            stall_pattern <= ($urandom_range(0, 2) == 0) ? 16'hFFFF : 16'($urandom);
        end
        m_tready <= stall_pattern[stall_step[3:0]];
        stall_step <= stall_step + 6'd1;
    end

    task automatic send_byte(input logic [7:0] rx, input logic act, input logic [7:0] elen);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 5);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(negedge clk);
            end
            burst_left = $urandom_range(1, 20);
        end
        s_tdata <= {elen, rx};
        s_tuser <= act;
        s_tvalid <= 1'b1;
        do
            @(negedge clk);
        while (!s_accept);
        burst_left--;
        items_sent++;
    endtask

    task automatic send_frame(input logic act, input logic [7:0] elen, input logic [7:0] hdr,
                              input logic [7:0] len, input logic [7:0] cmd, input bit corrupt);
        logic [7:0] body [256];
        logic [7:0] crc;
        int         n;
        int         i;
        n = act ? int'(elen) : 0;
        crc = crc8_update(8'h00, hdr);
        crc = crc8_update(crc, len);
        crc = crc8_update(crc, cmd);
        for (i = 0; i < n; i++)
        begin
            body[i] = 8'($urandom);
            crc = crc8_update(crc, body[i]);
        end
        if (corrupt)
        begin
            crc = crc ^ 8'($urandom_range(1, 255));
        end
        // Only the header request's mode and length count; the rest carry noise there.
        send_byte(hdr, act, elen);
        send_byte(len, 1'($urandom), 8'($urandom));
        send_byte(cmd, 1'($urandom), 8'($urandom));
        send_byte(crc, 1'($urandom), 8'($urandom));
        for (i = 0; i < n; i++)
        begin
            send_byte(body[i], 1'($urandom), 8'($urandom));
        end
    endtask

    task automatic send_random_frame();
        logic       act;
        logic [7:0] elen;
        logic [7:0] len;
        logic [7:0] cmd;
        int         n;
        if ($urandom_range(0, 9) == 0)
        begin
            n = $urandom_range(1, 3);
            repeat (n) send_byte(8'($urandom), 1'($urandom), 8'($urandom));
        end
        else
        begin
            act = 1'($urandom);
            if ($urandom_range(0, 59) == 0)
                elen = 8'($urandom_range(7, 255));
            else
                elen = 8'($urandom_range(0, 6));
            case ($urandom_range(0, 4))
                0:       cmd = code_mc;
                1:       cmd = code_ns;
                2:       cmd = code_pe;
                default: cmd = 8'($urandom);
            endcase
            if ($urandom_range(0, 7) == 0)
                len = 8'($urandom);
            else
                len = act ? elen : 8'h00;
            send_frame(act, elen, 8'($urandom), len, cmd, $urandom_range(0, 9) == 0);
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (outstanding != 0) @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic load_codes(input logic [7:0] mc, input logic [7:0] ns, input logic [7:0] pe);
        code_mc = mc;
        code_ns = ns;
        code_pe = pe;
        cfg_wr_en <= 1'b1;
        cfg_addr <= REG_MOTION_CONFLICT;
        cfg_wdata <= mc;
        @(negedge clk);
        cfg_addr <= REG_NOT_SUPPORTED;
        cfg_wdata <= ns;
        @(negedge clk);
        cfg_addr <= REG_PARAM_ERROR;
        cfg_wdata <= pe;
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    initial
    begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    initial
    begin
        int         ph;
        int         goal;
        logic [7:0] shared;
        repeat (6) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // All codes are still zero after reset, so command zero reads as a motion conflict.
        send_frame(1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
        drain();
        load_codes(8'h11, 8'h22, 8'h33);
        send_frame(1'b0, 8'hFF, 8'hFF, 8'h00, 8'h33, 1'b0);
        send_frame(1'b0, 8'h00, 8'h5A, 8'h00, 8'h22, 1'b0);
        send_frame(1'b0, 8'h00, 8'hA5, 8'h01, 8'h11, 1'b0);
        send_frame(1'b1, 8'h00, 8'h3C, 8'h00, 8'h5A, 1'b0);
        send_frame(1'b1, 8'h02, 8'hC3, 8'h03, 8'h44, 1'b0);

        for (ph = 0; ph < 5; ph++)
        begin
            drain();
            case (ph)
                0: load_codes(8'($urandom), 8'($urandom), 8'($urandom));
                1: load_codes(8'hFF, 8'hFF, 8'hFF);
                2:
                begin
                    shared = 8'($urandom);
                    load_codes(shared, shared, shared);
                end
                3: load_codes(8'h00, 8'h00, 8'h00);
                default: load_codes(8'($urandom), 8'($urandom), 8'($urandom));
            endcase
            if (ph == 1)
            begin
                send_frame(1'b1, 8'hFF, 8'($urandom), 8'hFF, 8'($urandom), 1'b0);
            end
            goal = items_sent + 50;
            while (items_sent < goal) send_random_frame();
        end

        drain();
        if (fail_count == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
